FILE: rtl/cd_pkg.sv
// Package for the circular deque: request and status codes,
// and the control group that the top level sends to every cell.
// No dependencies.
package cd_pkg;

    localparam int DATA_W = 32;
    localparam int REQ_W  = 2;
    localparam int STAT_W = 2;

    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
    } cell_ctrl_t;

endpackage

FILE: rtl/cd_cell.sv
// One storage cell of the deque row: a word and an occupied flag.
// Takes data from its neighbours on front shifts. Depends on cd_pkg.
module cd_cell
    import cd_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cell_ctrl_t               ctrl,
    input  logic signed [DATA_W-1:0] push_value,
    input  logic signed [DATA_W-1:0] left_data,
    input  logic                     left_occ,
    input  logic signed [DATA_W-1:0] right_data,
    input  logic                     right_occ,
    output logic signed [DATA_W-1:0] data,
    output logic                     occ,
    output logic signed [DATA_W-1:0] tail_tap
);

    logic signed [DATA_W-1:0] data_reg, data_next;
    logic                     occ_reg, occ_next;
    logic                     is_tail;
    logic                     is_first_free;

    assign is_tail       = occ_reg && !right_occ;
    assign is_first_free = !occ_reg && left_occ;

    always_comb begin
        data_next = data_reg;
        occ_next  = occ_reg;
        if (ctrl.push_front) begin
            data_next = left_data;
            occ_next  = left_occ;
        end else if (ctrl.pop_front) begin
            data_next = right_data;
            occ_next  = right_occ;
        end else if (ctrl.push_back && is_first_free) begin
            data_next = push_value;
            occ_next  = 1'b1;
        end else if (ctrl.pop_back && is_tail) begin
            occ_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign occ      = occ_reg;
    assign tail_tap = is_tail ? data_reg : '0;

endmodule

FILE: rtl/circular_deque.sv
// Channel   Ports            Payload
// input     s_t*             tdata: push_value[31:0]; tuser: req_type[1:0]
// result    m_t*             tdata: pop_value[31:0];  tuser: status[1:0]
//
// Top level of the double-ended queue: a row of DEPTH cd_cell instances,
// front at cell 0, occupied cells packed from cell 0 up. Depends on cd_pkg.
// One item per cycle while m_tready allows; result registered, valid in the cycle after acceptance.
// s_tready is high while the result register is empty or being taken.
// Reset (aresetn low, synchronous) empties the row; data words are not cleared.
// Pop back reads the last occupied cell through an AND-OR over the row.
module circular_deque
    import cd_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // push_value[31:0]
    input  logic [REQ_W-1:0]  s_tuser,   // req_type[1:0]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // pop_value[31:0]
    output logic [STAT_W-1:0] m_tuser    // status[1:0]
);

    logic signed [DATA_W-1:0] cell_data [DEPTH];
    logic signed [DATA_W-1:0] cell_tap  [DEPTH];
    logic [DEPTH-1:0]         occ_vec;
    logic signed [DATA_W-1:0] back_value;
    logic signed [DATA_W-1:0] push_value;
    cell_ctrl_t               ctrl;
    logic                     accept;
    logic                     is_full;
    logic                     is_empty;

    logic                     m_valid_reg, m_valid_next;
    logic signed [DATA_W-1:0] m_data_reg, m_data_next;
    logic [STAT_W-1:0]        m_user_reg, m_user_next;

    assign push_value = s_tdata;
    assign s_tready   = !m_valid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;
    assign is_full    = occ_vec[DEPTH-1];
    assign is_empty   = !occ_vec[0];

    always_comb begin
        ctrl.push_front = accept && (s_tuser == REQ_PUSH_FRONT) && !is_full;
        ctrl.push_back  = accept && (s_tuser == REQ_PUSH_BACK)  && !is_full;
        ctrl.pop_front  = accept && (s_tuser == REQ_POP_FRONT)  && !is_empty;
        ctrl.pop_back   = accept && (s_tuser == REQ_POP_BACK)   && !is_empty;
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic signed [DATA_W-1:0] l_data, r_data;
            logic                     l_occ, r_occ;
            if (gi == 0) begin : g_first
                assign l_data = push_value;
                assign l_occ  = 1'b1;
            end else begin : g_mid_l
                assign l_data = cell_data[gi-1];
                assign l_occ  = occ_vec[gi-1];
            end
            if (gi == DEPTH-1) begin : g_last
                assign r_data = '0;
                assign r_occ  = 1'b0;
            end else begin : g_mid_r
                assign r_data = cell_data[gi+1];
                assign r_occ  = occ_vec[gi+1];
            end
            cd_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .push_value (push_value),
                .left_data  (l_data),
                .left_occ   (l_occ),
                .right_data (r_data),
                .right_occ  (r_occ),
                .data       (cell_data[gi]),
                .occ        (occ_vec[gi]),
                .tail_tap   (cell_tap[gi])
            );
        end
    endgenerate

    // only the last occupied cell drives a non-zero tap
    always_comb begin
        back_value = '0;
        for (int i = 0; i < DEPTH; i++) begin
            back_value = back_value | cell_tap[i];
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            m_valid_next = 1'b1;
            m_data_next  = '0;
            m_user_next  = ST_OK;
            case (s_tuser)
                REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
                    if (is_full) begin
                        m_user_next = ST_OVERFLOW;
                    end
                end
                REQ_POP_FRONT: begin
                    if (is_empty) begin
                        m_user_next = ST_UNDERFLOW;
                    end else begin
                        m_data_next = cell_data[0];
                    end
                end
                REQ_POP_BACK: begin
                    if (is_empty) begin
                        m_user_next = ST_UNDERFLOW;
                    end else begin
                        m_data_next = back_value;
                    end
                end
                default: begin
                    m_user_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // occupied cells always form a run from cell 0
    a_occ_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        (occ_vec & (occ_vec + 1'b1)) == '0)
        else $error("occupancy not packed from cell 0");

    a_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_full && (s_tuser == REQ_PUSH_BACK || s_tuser == REQ_PUSH_FRONT))
        |=> (m_tuser == ST_OVERFLOW) && $stable(occ_vec))
        else $error("push into full deque not reported or changed state");

    a_pop_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.pop_front || ctrl.pop_back)
        |=> ($countones(occ_vec) + 1 == $past($countones(occ_vec))))
        else $error("pop did not remove exactly one element");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.push_front || ctrl.push_back)
        |=> ($countones(occ_vec) == $past($countones(occ_vec)) + 1))
        else $error("push did not add exactly one element");

endmodule
